FILE: sv/dlt_pkg.sv
// Shared types, state codes and transition tables for the duty level tracker.
// No dependencies; imported by every module of the block.
package dlt_pkg;

    localparam int DUTY_W  = 7;
    localparam int STATE_W = 5;
    localparam int LEVEL_W = 3;
    localparam int READINGS = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR_100 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_80  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_60  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_40  = 3'd3;

    localparam logic [DUTY_W-1:0] THR_100_RST = 7'd95;
    localparam logic [DUTY_W-1:0] THR_80_RST  = 7'd80;
    localparam logic [DUTY_W-1:0] THR_60_RST  = 7'd60;
    localparam logic [DUTY_W-1:0] THR_40_RST  = 7'd40;

    // quantized levels
    localparam logic [LEVEL_W-1:0] LVL_20  = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_40  = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_60  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_80  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_100 = 3'd4;

    // settled states
    localparam logic [STATE_W-1:0] ST_S20  = 5'd0;
    localparam logic [STATE_W-1:0] ST_S40  = 5'd1;
    localparam logic [STATE_W-1:0] ST_S60  = 5'd2;
    localparam logic [STATE_W-1:0] ST_S80  = 5'd3;
    localparam logic [STATE_W-1:0] ST_S100 = 5'd4;
    // transition states
    localparam logic [STATE_W-1:0] ST_T20_40   = 5'd5;
    localparam logic [STATE_W-1:0] ST_T20_80   = 5'd6;
    localparam logic [STATE_W-1:0] ST_T20_100  = 5'd7;
    localparam logic [STATE_W-1:0] ST_T40_20   = 5'd8;
    localparam logic [STATE_W-1:0] ST_T40_60   = 5'd9;
    localparam logic [STATE_W-1:0] ST_T40_100  = 5'd10;
    localparam logic [STATE_W-1:0] ST_T60_20   = 5'd11;
    localparam logic [STATE_W-1:0] ST_T60_40   = 5'd12;
    localparam logic [STATE_W-1:0] ST_T60_80   = 5'd13;
    localparam logic [STATE_W-1:0] ST_T80_20   = 5'd14;
    localparam logic [STATE_W-1:0] ST_T80_60   = 5'd15;
    localparam logic [STATE_W-1:0] ST_T100_20  = 5'd16;
    localparam logic [STATE_W-1:0] ST_T100_40  = 5'd17;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [DUTY_W-1:0] thr_100;
        logic [DUTY_W-1:0] thr_80;
        logic [DUTY_W-1:0] thr_60;
        logic [DUTY_W-1:0] thr_40;
    } thr_t;

    // classified request handed from front to back
    typedef struct packed {
        logic               stable;
        logic [LEVEL_W-1:0] level;
    } cls_t;

    function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] st,
                                                      input logic [LEVEL_W-1:0] lvl);
        logic [STATE_W-1:0] ns;
        ns = st;
        case (st)
            ST_S20:
                case (lvl)
                    LVL_40:  ns = ST_T20_40;
                    LVL_80:  ns = ST_T20_80;
                    LVL_100: ns = ST_T20_100;
                    default: ns = ST_S20;
                endcase
            ST_S40:
                case (lvl)
                    LVL_20:  ns = ST_T40_20;
                    LVL_60:  ns = ST_T40_60;
                    LVL_100: ns = ST_T40_100;
                    default: ns = ST_S40;
                endcase
            ST_S60:
                case (lvl)
                    LVL_20:  ns = ST_T60_20;
                    LVL_40:  ns = ST_T60_40;
                    LVL_80:  ns = ST_T60_80;
                    default: ns = ST_S60;
                endcase
            ST_S80:
                case (lvl)
                    LVL_20:  ns = ST_T80_20;
                    LVL_60:  ns = ST_T80_60;
                    default: ns = ST_S80;
                endcase
            ST_S100:
                case (lvl)
                    LVL_20:  ns = ST_T100_20;
                    LVL_40:  ns = ST_T100_40;
                    default: ns = ST_S100;
                endcase
            ST_T20_40:  ns = ST_S40;
            ST_T20_80:  ns = ST_S80;
            ST_T20_100: ns = ST_S100;
            ST_T40_20:  ns = ST_S20;
            ST_T40_60:  ns = ST_S60;
            ST_T40_100: ns = ST_S100;
            ST_T60_20:  ns = ST_S20;
            ST_T60_40:  ns = ST_S40;
            ST_T60_80:  ns = ST_S80;
            ST_T80_20:  ns = ST_S20;
            ST_T80_60:  ns = ST_S60;
            ST_T100_20: ns = ST_S20;
            ST_T100_40: ns = ST_S40;
            default:    ns = st;   // unused codes hold
        endcase
        return ns;
    endfunction

endpackage

FILE: sv/dlt_front.sv
// Front end: clamps the readings, checks stability and quantizes the level.
// Depends on dlt_pkg.
module dlt_front import dlt_pkg::*; #(
    parameter int SAMPLES = 6
) (
    input  logic [DUTY_W-1:0] rd [READINGS],
    input  thr_t              thr,
    output cls_t              cls
);

    localparam int USED = (SAMPLES < READINGS) ? SAMPLES : READINGS;

    logic [DUTY_W-1:0] clamped [READINGS];
    logic              stable;
    logic [LEVEL_W-1:0] level;

    always_comb
    begin
        for (int i = 0; i < READINGS; i++)
        begin
            clamped[i] = (rd[i] > DUTY_FULL) ? DUTY_FULL : rd[i];
        end
        stable = 1'b1;
        for (int i = 1; i < USED; i++)
        begin
            if (clamped[i] != clamped[0])
            begin
                stable = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (!stable)
            level = LVL_20;
        else if (clamped[0] >= thr.thr_100)
            level = LVL_100;
        else if (clamped[0] >= thr.thr_80)
            level = LVL_80;
        else if (clamped[0] >= thr.thr_60)
            level = LVL_60;
        else if (clamped[0] >= thr.thr_40)
            level = LVL_40;
        else
            level = LVL_20;
    end

    assign cls.stable = stable;
    assign cls.level  = level;

endmodule

FILE: sv/dlt_queue.sv
// Short request queue between the classifier and the state machine.
// Depends on dlt_pkg.
module dlt_queue import dlt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    input  logic pop,
    output cls_t head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: sv/dlt_back.sv
// Back end: door state machine and registered result stage.
// Depends on dlt_pkg.
module dlt_back import dlt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cls_t               head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STATE_W-1:0] door_state_code,
    output logic               reading_stable,
    output logic [LEVEL_W-1:0] level_index
);

    logic [STATE_W-1:0] state_reg, state_next;
    logic               valid_reg;
    logic [STATE_W-1:0] code_reg;
    logic               stable_reg;
    logic [LEVEL_W-1:0] level_reg;

    // result slot frees up when empty or being taken this cycle
    assign pop = !empty && (!valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        if (head.stable)
            state_next = next_state(state_reg, head.level);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_S20;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg   <= state_next;
            stable_reg <= head.stable;
            level_reg  <= head.level;
        end
    end

    assign out_valid       = valid_reg;
    assign door_state_code = code_reg;
    assign reading_stable  = stable_reg;
    assign level_index     = level_reg;

endmodule

FILE: sv/duty_level_transition_fsm.sv
// Door duty level tracker: one request in, one result out, one per cycle sustained while out_stall is low.
// Each request is written into the queue, then popped into the result register.
// Throughput: 1 request per cycle while out_stall is low, set by the single state update in the back end.
// Reset (rst_n low, async): state settled at 20 percent, thresholds 95/80/60/40,
// queue empty, no result valid.
// Depends on dlt_pkg, dlt_front, dlt_queue, dlt_back.
module duty_level_transition_fsm import dlt_pkg::*; #(
    parameter int SAMPLES_PER_ITEM = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DUTY_W-1:0]    reading_0,
    input  logic [DUTY_W-1:0]    reading_1,
    input  logic [DUTY_W-1:0]    reading_2,
    input  logic [DUTY_W-1:0]    reading_3,
    input  logic [DUTY_W-1:0]    reading_4,
    input  logic [DUTY_W-1:0]    reading_5,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATE_W-1:0]   door_state_code,
    output logic                 reading_stable,
    output logic [LEVEL_W-1:0]   level_index,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUTY_W-1:0]    cfg_data
);

    // threshold registers; writes happen only while idle is a rule for the user, the block does not enforce it
    thr_t thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.thr_100 <= THR_100_RST;
            thr_reg.thr_80  <= THR_80_RST;
            thr_reg.thr_60  <= THR_60_RST;
            thr_reg.thr_40  <= THR_40_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THR_100: thr_reg.thr_100 <= cfg_data;
                REG_THR_80:  thr_reg.thr_80  <= cfg_data;
                REG_THR_60:  thr_reg.thr_60  <= cfg_data;
                REG_THR_40:  thr_reg.thr_40  <= cfg_data;
                default:     ;   // unmapped index, ignored
            endcase
        end
    end

    logic [DUTY_W-1:0] rd [READINGS];
    cls_t              cls;
    cls_t              head;
    logic              q_empty, q_full, q_pop;
    logic              accept;

    assign rd[0] = reading_0;
    assign rd[1] = reading_1;
    assign rd[2] = reading_2;
    assign rd[3] = reading_3;
    assign rd[4] = reading_4;
    assign rd[5] = reading_5;

    // stall only on a full queue; a pending result does not block intake
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // front: classification is combinational, captured by the queue write
    dlt_front #(
        .SAMPLES (SAMPLES_PER_ITEM)
    ) u_front (
        .rd  (rd),
        .thr (thr_reg),
        .cls (cls)
    );

    dlt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (cls),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back: state machine advances as each request leaves the queue
    dlt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (q_empty),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .door_state_code (door_state_code),
        .reading_stable  (reading_stable),
        .level_index     (level_index)
    );

endmodule

FILE: sv/dlt_checker.sv
// Port-level checks for the duty level tracker, bound to the top level.
// Depends on dlt_pkg and duty_level_transition_fsm.
module dlt_checker import dlt_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [STATE_W-1:0] door_state_code,
    input logic               reading_stable,
    input logic [LEVEL_W-1:0] level_index
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(door_state_code)
                                 && $stable(reading_stable) && $stable(level_index))
        else $error("result changed while stalled");

    // unstable requests report the lowest level
    a_unstable_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reading_stable |-> level_index == LVL_20)
        else $error("level set on unstable request");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reading_stable |-> level_index <= LVL_100)
        else $error("level out of range");

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> door_state_code <= ST_T100_40)
        else $error("state code out of range");

endmodule

bind duty_level_transition_fsm dlt_checker u_chk (.*);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for duty_level_transition_fsm: directed and random requests.
// Results are checked against a local model of the quantizer and the state machine.
// Depends on dlt_pkg and duty_level_transition_fsm.
module testbench;
    import dlt_pkg::*;

    // indexes past the last threshold register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int HOLD_CYCLES = 40;   // long receiver hold-off, fills the queue
    localparam int TAIL_CYCLES = 10;   // leave margin before the summary
    localparam int PHASES      = 7;

    typedef logic [DUTY_W-1:0] duty_t;
    typedef logic [READINGS-1:0][DUTY_W-1:0] readings_t;

    typedef struct packed {
        logic [STATE_W-1:0] code;
        logic               stable;
        logic [LEVEL_W-1:0] level;
    } door_result_t;

    // Tracks thresholds and door state, predicts one result per request.
    class door_scoreboard;
        logic [STATE_W-1:0] door_state;
        duty_t              thr [4];
        logic [STATE_W-1:0] from_settled [5][5];
        logic [STATE_W-1:0] settle_target [13];
        door_result_t       expected_q [$];
        int                 errors;
        int                 checked;
        int                 accepted;
        int                 stable_seen;

        function new();
            door_state = ST_S20;
            thr = '{THR_100_RST, THR_80_RST, THR_60_RST, THR_40_RST};
            // row: settled state, column: quantized level
            from_settled = '{'{ST_S20, ST_T20_40, ST_S20, ST_T20_80, ST_T20_100},
                             '{ST_T40_20, ST_S40, ST_T40_60, ST_S40, ST_T40_100},
                             '{ST_T60_20, ST_T60_40, ST_S60, ST_T60_80, ST_S60},
                             '{ST_T80_20, ST_S80, ST_T80_60, ST_S80, ST_S80},
                             '{ST_T100_20, ST_T100_40, ST_S100, ST_S100, ST_S100}};
            settle_target = '{ST_S40, ST_S80, ST_S100, ST_S20, ST_S60, ST_S100, ST_S20,
                              ST_S40, ST_S80, ST_S20, ST_S60, ST_S20, ST_S40};
            errors      = 0;
            checked     = 0;
            accepted    = 0;
            stable_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, duty_t data);
            if (idx <= REG_THR_40)
                thr[idx] = data;
        endfunction

        function duty_t clamp(duty_t d);
            return (d > DUTY_FULL) ? DUTY_FULL : d;
        endfunction

        function logic [LEVEL_W-1:0] quantize(duty_t d);
            if (d >= thr[REG_THR_100]) return LVL_100;
            if (d >= thr[REG_THR_80])  return LVL_80;
            if (d >= thr[REG_THR_60])  return LVL_60;
            if (d >= thr[REG_THR_40])  return LVL_40;
            return LVL_20;
        endfunction

        function void note_request(readings_t r);
            duty_t        ref_duty;
            door_result_t res;
            ref_duty   = clamp(r[0]);
            res.stable = 1'b1;
            for (int i = 1; i < READINGS; i++)
                if (clamp(r[i]) != ref_duty)
                    res.stable = 1'b0;
            res.level = LVL_20;
            if (res.stable)
            begin
                res.level = quantize(ref_duty);
                if (door_state <= ST_S100)
                    door_state = from_settled[door_state][res.level];
                else if (door_state <= ST_T100_40)
                    door_state = settle_target[door_state - ST_T20_40];
                stable_seen++;
            end
            res.code = door_state;
            expected_q.push_back(res);
            accepted++;
        endfunction

        function void check_result(logic [STATE_W-1:0] code, logic stable,
                                   logic [LEVEL_W-1:0] level);
            door_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, state %0d stable %0d level %0d",
                         $time, code, stable, level);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (code !== want.code)
            begin
                $display("%0t: door_state_code mismatch, expected %0d, actual %0d",
                         $time, want.code, code);
                errors++;
            end
            if (stable !== want.stable)
            begin
                $display("%0t: reading_stable mismatch, expected %0d, actual %0d",
                         $time, want.stable, stable);
                errors++;
            end
            if (level !== want.level)
            begin
                $display("%0t: level_index mismatch, expected %0d, actual %0d",
                         $time, want.level, level);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    readings_t            rd;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATE_W-1:0]   door_state_code;
    logic                 reading_stable;
    logic [LEVEL_W-1:0]   level_index;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    duty_t                cfg_data;

    door_scoreboard sb;
    int             send_idle_max;
    int             recv_idle_max;
    bit             hold_req;
    int             settings_used;

    duty_level_transition_fsm dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .reading_0       (rd[0]),
        .reading_1       (rd[1]),
        .reading_2       (rd[2]),
        .reading_3       (rd[3]),
        .reading_4       (rd[4]),
        .reading_5       (rd[5]),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .door_state_code (door_state_code),
        .reading_stable  (reading_stable),
        .level_index     (level_index),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Monitor: everything is sampled at the rising edge. The result is checked
    // before the request of the same edge is noted; a request passes the queue and
    // then the result register, so the two can never belong together.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result(door_state_code, reading_stable, level_index);
        if (in_valid && !in_stall)
            sb.note_request(rd);
        if (cfg_we)
            sb.write_reg(cfg_index, cfg_data);
    end

    // Result side: random stall before every result, plus one long hold-off on
    // request. The hold is counted here so the sender keeps pushing meanwhile.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = $urandom_range(0, recv_idle_max);
            out_stall = (gap > 0);
            repeat (gap) @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Request driver; starts and ends at a falling edge. Valid is only lowered
    // when an idle gap is drawn, so a back-to-back request keeps it high.
    task automatic send_request(input readings_t r);
        int gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rd       = r;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_uniform(input duty_t v);
        send_request({READINGS{v}});
    endtask

    // Sender pause: nothing offered until every expected result is back.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input duty_t data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Threshold update only with the block idle; a write to a spare index rides along.
    task automatic set_thresholds(input duty_t t100, input duty_t t80,
                                  input duty_t t60, input duty_t t40);
        wait_drained();
        repeat (3) @(negedge clk);
        write_cfg(REG_THR_100, t100);
        write_cfg(REG_THR_80, t80);
        write_cfg(REG_THR_60, t60);
        write_cfg(REG_THR_40, t40);
        write_cfg(logic'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)) ? 
                  CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)) : REG_SPARE_HI,
                  duty_t'($urandom));
        settings_used++;
    endtask

    // Duty value biased toward zero, the clamp region and the threshold edges.
    function automatic duty_t pick_duty();
        duty_t t;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return duty_t'($urandom_range(DUTY_FULL, 127));
            2, 3:
            begin
                t = sb.thr[$urandom_range(0, 3)];
                return t + duty_t'($urandom_range(0, 2)) - duty_t'(1);
            end
            default: return duty_t'($urandom_range(0, DUTY_FULL));
        endcase
    endfunction

    // Mostly stable requests (the only ones that move the state machine),
    // some with one reading broken, a few pure noise.
    function automatic readings_t make_request();
        readings_t r;
        duty_t     v;
        v = pick_duty();
        r = {READINGS{v}};
        case ($urandom_range(0, 19))
            0, 1, 2: r[$urandom_range(0, READINGS - 1)] = pick_duty();
            3:
                for (int i = 0; i < READINGS; i++)
                    r[i] = duty_t'($urandom);
            default:
                // above full scale the readings may differ and still count as equal
                if (v >= DUTY_FULL)
                    for (int i = 0; i < READINGS; i++)
                        r[i] = duty_t'($urandom_range(DUTY_FULL, 127));
        endcase
        return r;
    endfunction

    initial
    begin
        duty_t walk [17];
        int    phase_items [PHASES];
        duty_t t [4];

        walk          = '{7'd0, 7'd39, 7'd40, 7'd40, 7'd60, 7'd60, 7'd95, 7'd80, 7'd79,
                          7'd59, 7'd60, 7'd0, 7'd20, 7'd100, 7'd80, 7'd96, 7'd0};
        phase_items   = '{180, 150, 100, 150, 250, 250, 250};
        sb            = new();
        send_idle_max = 5;
        recv_idle_max = 5;
        hold_req      = 1'b0;
        settings_used = 1;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rd            = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_THR_100;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walk with reset thresholds 95/80/60/40.
        send_uniform(7'd0);                     // low level keeps settled 20
        send_uniform(7'd127);                   // clamped to 100: start 20->100
        send_request({7'd105, 7'd120, 7'd110, 7'd100, 7'd127, 7'd101}); // equal once clamped
        send_uniform(7'd70);                    // 60 ignored at settled 100
        send_uniform(7'd85);                    // 80 ignored too
        send_uniform(7'd50);                    // 100->40
        send_request({7'd51, {5{7'd50}}});      // last reading off: no move
        send_request({{5{7'd50}}, 7'd49});      // reference reading off: no move
        // transition completes on any stable level, then a tour of the table
        foreach (walk[i])
            send_uniform(walk[i]);

        // Random phases, each with its own thresholds.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1: set_thresholds(7'd0, 7'd0, 7'd0, 7'd0);         // everything is 100
                2: set_thresholds(7'd127, 7'd127, 7'd127, 7'd127); // nothing reachable
                3: set_thresholds(7'd100, 7'd100, 7'd100, 7'd100);
                4:
                begin
                    foreach (t[i])
                        t[i] = duty_t'($urandom_range(0, DUTY_FULL));
                    t.rsort();
                    set_thresholds(t[0], t[1], t[2], t[3]);
                end
                5: set_thresholds(duty_t'($urandom), duty_t'($urandom),
                                  duty_t'($urandom), duty_t'($urandom));
                6: set_thresholds(THR_100_RST, THR_80_RST, THR_60_RST, THR_40_RST);
                default: ;
            endcase
            // phase 3 runs with no idling on either side
            send_idle_max = (ph == 3) ? 0 : 5;
            recv_idle_max = (ph == 3) ? 0 : 5;
            for (int n = 0; n < phase_items[ph]; n++)
            begin
                // back-to-back requests against a long result hold-off
                if (ph == 6 && n == 20)
                begin
                    send_idle_max = 0;
                    hold_req      = 1'b1;
                end
                if (ph == 6 && n == 80)
                    send_idle_max = 5;
                if (ph == 4 && n == 120)
                    wait_drained();
                send_request(make_request());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d requests (%0d stable) under %0d threshold settings",
                 sb.accepted, sb.stable_seen, settings_used);
        $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
